// File: design/riscv_instruction_field_decoder_top_assert.svh
// assertion macros for the instruction field decoder top level
`ifndef RISCV_INSTRUCTION_FIELD_DECODER_TOP_ASSERT_SVH
`define RISCV_INSTRUCTION_FIELD_DECODER_TOP_ASSERT_SVH

// concurrent check on an explicit clock and active-low reset
`define RVFD_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// concurrent check on the usual clk_i / rst_ni pair
`define RVFD_ASSERT(label, prop) \
  `RVFD_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// File: design/rvfd_pkg.sv
// types, codes and widths shared by the instruction field decoder
package rvfd_pkg;

  localparam int unsigned INSTR_W = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned IMM_W   = 32;
  localparam int unsigned RES_W   = 56;

  // major opcodes, bits 6:0
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_STORE = 7'h23;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_JAL   = 7'h6f;

  // funct7 selectors for add/sub and srl/sra
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_LD   = 3'd3;
  localparam logic [2:0] F3_LWU  = 3'd6;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;

  typedef enum logic [2:0] {
    FMT_OPIMM = 3'd0,
    FMT_LOAD  = 3'd1,
    FMT_REG   = 3'd2,
    FMT_STORE = 3'd3,
    FMT_LUI   = 3'd4,
    FMT_JAL   = 3'd5
  } fmt_e;

  typedef enum logic [4:0] {
    MN_INVALID = 5'd0,
    MN_ADDI    = 5'd1,
    MN_SLTI    = 5'd2,
    MN_SLTIU   = 5'd3,
    MN_XORI    = 5'd4,
    MN_ORI     = 5'd5,
    MN_ANDI    = 5'd6,
    MN_LWU     = 5'd7,
    MN_LD      = 5'd8,
    MN_ADD     = 5'd9,
    MN_SUB     = 5'd10,
    MN_SLL     = 5'd11,
    MN_SLT     = 5'd12,
    MN_SLTU    = 5'd13,
    MN_XOR     = 5'd14,
    MN_SRL     = 5'd15,
    MN_SRA     = 5'd16,
    MN_OR      = 5'd17,
    MN_AND     = 5'd18,
    MN_SB      = 5'd19,
    MN_SH      = 5'd20,
    MN_SW      = 5'd21,
    MN_LUI     = 5'd22,
    MN_JAL     = 5'd23
  } mnem_e;

  // first member in the top bits, so valid_res lands in bit 0 when flattened
  typedef struct packed {
    logic signed [IMM_W-1:0] immediate;
    logic [REG_W-1:0]        src_reg2;
    logic [REG_W-1:0]        src_reg1;
    logic [REG_W-1:0]        dest_reg;
    mnem_e                   mnemonic;
    fmt_e                    format;
    logic                    valid_res;
  } dec_res_t;

endpackage

// File: design/rvfd_pipe_reg.sv
// one valid/ready register stage with full throughput
module rvfd_pipe_reg #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // take a new beat when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/rvfd_decode.sv
// field split, mnemonic lookup and immediate assembly for one instruction word
module rvfd_decode (
  input  logic [rvfd_pkg::INSTR_W-1:0] instr_i,
  output rvfd_pkg::dec_res_t           res_o
);
  import rvfd_pkg::*;

  logic [6:0]       opc;
  logic [2:0]       f3;
  logic [6:0]       f7;
  logic [REG_W-1:0] rd;
  logic [REG_W-1:0] rs1;
  logic [REG_W-1:0] rs2;
  logic [IMM_W-1:0] imm_i;
  logic [IMM_W-1:0] imm_s;
  logic [IMM_W-1:0] imm_u;
  logic [IMM_W-1:0] imm_j;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign rs1 = instr_i[19:15];
  assign rs2 = instr_i[24:20];
  assign f7  = instr_i[31:25];

  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_u = {instr_i[31:12], 12'h000};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};

  always_comb begin
    res_o = '0;
    case (opc)
      OPC_OPIMM: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_OPIMM;
        res_o.dest_reg  = rd;
        res_o.src_reg1  = rs1;
        res_o.immediate = imm_i;
        case (f3)
          F3_ADD:  res_o.mnemonic = MN_ADDI;
          F3_SLT:  res_o.mnemonic = MN_SLTI;
          F3_SLTU: res_o.mnemonic = MN_SLTIU;
          F3_XOR:  res_o.mnemonic = MN_XORI;
          F3_OR:   res_o.mnemonic = MN_ORI;
          F3_AND:  res_o.mnemonic = MN_ANDI;
          default: res_o.mnemonic = MN_INVALID;
        endcase
      end
      OPC_LOAD: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_LOAD;
        res_o.dest_reg  = rd;
        res_o.src_reg1  = rs1;
        res_o.immediate = imm_i;
        case (f3)
          F3_LWU:  res_o.mnemonic = MN_LWU;
          F3_LD:   res_o.mnemonic = MN_LD;
          default: res_o.mnemonic = MN_INVALID;
        endcase
      end
      OPC_OP: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_REG;
        res_o.dest_reg  = rd;
        res_o.src_reg1  = rs1;
        res_o.src_reg2  = rs2;
        case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) res_o.mnemonic = MN_ADD;
            else if (f7 == F7_ALT) res_o.mnemonic = MN_SUB;
            else res_o.mnemonic = MN_INVALID;
          end
          F3_SLL:  res_o.mnemonic = MN_SLL;
          F3_SLT:  res_o.mnemonic = MN_SLT;
          F3_SLTU: res_o.mnemonic = MN_SLTU;
          F3_XOR:  res_o.mnemonic = MN_XOR;
          F3_SR: begin
            if (f7 == F7_BASE) res_o.mnemonic = MN_SRL;
            else if (f7 == F7_ALT) res_o.mnemonic = MN_SRA;
            else res_o.mnemonic = MN_INVALID;
          end
          F3_OR:   res_o.mnemonic = MN_OR;
          default: res_o.mnemonic = MN_AND;
        endcase
      end
      OPC_STORE: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_STORE;
        res_o.src_reg1  = rs1;
        res_o.src_reg2  = rs2;
        res_o.immediate = imm_s;
        case (f3)
          F3_SB:   res_o.mnemonic = MN_SB;
          F3_SH:   res_o.mnemonic = MN_SH;
          F3_SW:   res_o.mnemonic = MN_SW;
          default: res_o.mnemonic = MN_INVALID;
        endcase
      end
      OPC_LUI: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_LUI;
        res_o.mnemonic  = MN_LUI;
        res_o.dest_reg  = rd;
        res_o.immediate = imm_u;
      end
      OPC_JAL: begin
        res_o.valid_res = 1'b1;
        res_o.format    = FMT_JAL;
        res_o.mnemonic  = MN_JAL;
        res_o.dest_reg  = rd;
        res_o.immediate = imm_j;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// File: design/riscv_instruction_field_decoder_top.sv
// top level of the risc-v instruction field decoder (rv64i-style loads)
//
// usage
//   slave side: one 32-bit instruction word per beat on s_axis_tdata_i
//   master side: one decoded result per beat on m_axis_tdata_o, packed from
//     bit 0 up as valid_res, format, mnemonic, dest_reg, src_reg1, src_reg2,
//     immediate (56 bits, exactly seven bytes, no padding)
//   every input beat yields exactly one output beat, in order
// path and throughput
//   the input register takes each accepted word, the decode logic works on
//   it, and the result register loads the decoded beat once it has room,
//   which raises tvalid on the master side; one beat per cycle sustained
//   while m_axis_tready_i stays high, set by those two register stages
// reset
//   rst_ni low empties both stages at once; no beat is in flight afterwards
// stall
//   while the receiver holds m_axis_tready_i low the result register keeps
//   its beat and the input register can still take one more word; with both
//   full, s_axis_tready_o drops until the receiver takes a beat
`include "riscv_instruction_field_decoder_top_assert.svh"

module riscv_instruction_field_decoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rvfd_pkg::INSTR_W-1:0] s_axis_tdata_i,  // [31:0] instruction
  // master side
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [0] valid_res, [3:1] format, [8:4] mnemonic, [13:9] dest_reg,
  // [18:14] src_reg1, [23:19] src_reg2, [55:24] immediate
  output logic [rvfd_pkg::RES_W-1:0]   m_axis_tdata_o
);
  import rvfd_pkg::*;

  logic               instr_valid;
  logic               instr_ready;
  logic [INSTR_W-1:0] instr_q;
  dec_res_t           res_d;
  logic [RES_W-1:0]   res_bits;

  // input register: isolates the decode cone from the upstream timing
  rvfd_pipe_reg #(
    .Width (INSTR_W)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (instr_valid),
    .ready_i (instr_ready),
    .data_o  (instr_q)
  );

  // single pass of decode logic between the two registers
  rvfd_decode u_decode (
    .instr_i (instr_q),
    .res_o   (res_d)
  );

  assign res_bits = res_d;

  // result register: holds a beat while the receiver stalls
  rvfd_pipe_reg #(
    .Width (RES_W)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (instr_valid),
    .ready_o (instr_ready),
    .data_i  (res_bits),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

  // while the receiver is ready the input side never applies backpressure
  `RVFD_ASSERT(a_no_bubble_when_sink_ready, m_axis_tready_i |-> s_axis_tready_o)

  // a decoded word moves into the result register on the next edge
  `RVFD_ASSERT(a_decode_advances, (instr_valid && instr_ready) |=> m_axis_tvalid_o)

  // an unrecognised opcode leaves every other result field at zero
  `RVFD_ASSERT(a_invalid_is_clean,
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[RES_W-1:1] == '0))

  // lui and jal results never carry source registers
  `RVFD_ASSERT(a_u_j_no_sources,
    (m_axis_tvalid_o && (m_axis_tdata_o[3:1] == FMT_LUI || m_axis_tdata_o[3:1] == FMT_JAL))
      |-> (m_axis_tdata_o[23:14] == '0))

endmodule

// File: bench/rvfd_decode_checker.sv
`timescale 1ns / 1ps
// decode checker: predicts every result beat of the instruction decoder and compares it
module rvfd_decode_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [rvfd_pkg::INSTR_W-1:0] s_tdata_i,   // [31:0] instruction
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [rvfd_pkg::RES_W-1:0]   m_tdata_i,   // decoded result, valid_res in bit 0
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);
  import rvfd_pkg::*;

  typedef struct packed {
    logic [INSTR_W-1:0] word;
    dec_res_t           res;
  } decode_entry_t;

  decode_entry_t decoded_q[$];
  int unsigned   mis_cnt;
  int unsigned   chk_cnt;

  function automatic dec_res_t decode_instr(input logic [INSTR_W-1:0] w);
    dec_res_t    r;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [20:0] j_off;
    r = '0;
    f3 = w[14:12];
    f7 = w[31:25];
    r.valid_res = 1'b1;
    case (w[6:0])
      OPC_OPIMM: begin
        r.format   = FMT_OPIMM;
        r.dest_reg = w[11:7];
        r.src_reg1 = w[19:15];
        r.immediate = {{20{w[31]}}, w[31:20]};
        case (f3)
          F3_ADD:  r.mnemonic = MN_ADDI;
          F3_SLT:  r.mnemonic = MN_SLTI;
          F3_SLTU: r.mnemonic = MN_SLTIU;
          F3_XOR:  r.mnemonic = MN_XORI;
          F3_OR:   r.mnemonic = MN_ORI;
          F3_AND:  r.mnemonic = MN_ANDI;
          default: r.mnemonic = MN_INVALID;
        endcase
      end
      OPC_LOAD: begin
        r.format   = FMT_LOAD;
        r.dest_reg = w[11:7];
        r.src_reg1 = w[19:15];
        r.immediate = {{20{w[31]}}, w[31:20]};
        if (f3 == F3_LWU) r.mnemonic = MN_LWU;
        else if (f3 == F3_LD) r.mnemonic = MN_LD;
        else r.mnemonic = MN_INVALID;
      end
      OPC_OP: begin
        r.format   = FMT_REG;
        r.dest_reg = w[11:7];
        r.src_reg1 = w[19:15];
        r.src_reg2 = w[24:20];
        case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) r.mnemonic = MN_ADD;
            else if (f7 == F7_ALT) r.mnemonic = MN_SUB;
            else r.mnemonic = MN_INVALID;
          end
          F3_SLL:  r.mnemonic = MN_SLL;
          F3_SLT:  r.mnemonic = MN_SLT;
          F3_SLTU: r.mnemonic = MN_SLTU;
          F3_XOR:  r.mnemonic = MN_XOR;
          F3_SR: begin
            if (f7 == F7_BASE) r.mnemonic = MN_SRL;
            else if (f7 == F7_ALT) r.mnemonic = MN_SRA;
            else r.mnemonic = MN_INVALID;
          end
          F3_OR:   r.mnemonic = MN_OR;
          default: r.mnemonic = MN_AND;
        endcase
      end
      OPC_STORE: begin
        r.format   = FMT_STORE;
        r.src_reg1 = w[19:15];
        r.src_reg2 = w[24:20];
        r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_SB:   r.mnemonic = MN_SB;
          F3_SH:   r.mnemonic = MN_SH;
          F3_SW:   r.mnemonic = MN_SW;
          default: r.mnemonic = MN_INVALID;
        endcase
      end
      OPC_LUI: begin
        r.format    = FMT_LUI;
        r.mnemonic  = MN_LUI;
        r.dest_reg  = w[11:7];
        r.immediate = {w[31:12], 12'h000};
      end
      OPC_JAL: begin
        j_off = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.format    = FMT_JAL;
        r.mnemonic  = MN_JAL;
        r.dest_reg  = w[11:7];
        r.immediate = {{11{j_off[20]}}, j_off};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [INSTR_W-1:0] word,
                             input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (mis_cnt < 10)
        $display("%0t: %s wrong for word %h: expected %h, got %h",
                 $realtime, field, word, exp_v, act_v);
      mis_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decode_entry_t exp_e;
    dec_res_t      got;
    if (!rst_ni) begin
      decoded_q.delete();
      mis_cnt = 0;
      chk_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // result side first: a beat leaving now never belongs to a word entering now
      if (m_tvalid_i && m_tready_i) begin
        got = dec_res_t'(m_tdata_i);
        if (decoded_q.size() == 0) begin
          if (mis_cnt < 10)
            $display("%0t: result beat %h with no instruction outstanding",
                     $realtime, m_tdata_i);
          mis_cnt++;
        end else begin
          exp_e = decoded_q.pop_front();
          chk_cnt++;
          check_field("valid_res", exp_e.word, 32'(exp_e.res.valid_res),
                      32'(got.valid_res));
          check_field("format",    exp_e.word, 32'(exp_e.res.format),
                      32'(got.format));
          check_field("mnemonic",  exp_e.word, 32'(exp_e.res.mnemonic),
                      32'(got.mnemonic));
          check_field("dest_reg",  exp_e.word, 32'(exp_e.res.dest_reg),
                      32'(got.dest_reg));
          check_field("src_reg1",  exp_e.word, 32'(exp_e.res.src_reg1),
                      32'(got.src_reg1));
          check_field("src_reg2",  exp_e.word, 32'(exp_e.res.src_reg2),
                      32'(got.src_reg2));
          check_field("immediate", exp_e.word, exp_e.res.immediate, got.immediate);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        exp_e.word = s_tdata_i;
        exp_e.res  = decode_instr(s_tdata_i);
        decoded_q.push_back(exp_e);
      end
      mismatches_o <= mis_cnt;
      pending_o    <= $unsigned(decoded_q.size());
      checked_o    <= chk_cnt;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// top of the decoder bench: clock, reset, instruction stimulus, result back-pressure, verdict
module tb;
  import rvfd_pkg::*;

  localparam int unsigned RANDOM_WORDS = 750;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [INSTR_W-1:0]  s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RES_W-1:0]    m_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  // receiver pattern state
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  riscv_instruction_field_decoder_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  rvfd_decode_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // receiver back-pressure: the pattern switches between always ready, random
  // stalls of various density and a fixed periodic stall
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) != 0);
      3:       m_tready <= ((stall_phase % 7) > 2);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // pack an instruction word from its raw fields
  function automatic logic [INSTR_W-1:0] pack_instr(input logic [6:0] f7, input logic [4:0] rs2,
                                                    input logic [4:0] rs1, input logic [2:0] f3,
                                                    input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // mostly recognised groups with random content, the rest raw noise
  function automatic logic [INSTR_W-1:0] random_instr();
    logic [INSTR_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2:    w[6:0] = OPC_OPIMM;
      3, 4, 5: begin
        w[6:0] = OPC_LOAD;
        // lean on the two listed load widths
        if ($urandom_range(0, 1)) w[14:12] = $urandom_range(0, 1) ? F3_LWU : F3_LD;
      end
      6, 7, 8, 9: begin
        w[6:0] = OPC_OP;
        // funct7 mostly one of the two selectors so add/sub and srl/sra are hit
        case ($urandom_range(0, 4))
          0, 1:    w[31:25] = F7_BASE;
          2, 3:    w[31:25] = F7_ALT;
          default: ;
        endcase
      end
      10, 11, 12: w[6:0] = OPC_STORE;
      13, 14:     w[6:0] = OPC_LUI;
      15, 16:     w[6:0] = OPC_JAL;
      default:    ;
    endcase
    return w;
  endfunction

  // present one word and hold it until the decoder takes the beat
  task automatic push_word(input logic [INSTR_W-1:0] w);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // sender pacing: bursts of random length, random gaps between them,
  // and now and then a burst that runs straight into the next
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending until every outstanding result beat has come back
  task automatic hold_off();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    logic [2:0]  f3;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unrecognised opcodes: all zeros and all ones
    push_word(32'h0000_0000);
    push_word(32'hffff_ffff);
    // op-imm, every funct3 including the two unlisted ones, immediates at both ends
    for (k = 0; k < 8; k++) begin
      f3 = k[2:0];
      push_word(pack_instr(f3[0] ? 7'h40 : 7'h3f, f3[1] ? 5'h00 : 5'h1f, 5'(k * 4),
                           f3, 5'(31 - k), OPC_OPIMM));
    end
    // loads: lwu, ld and one unlisted width
    push_word(pack_instr(7'h3f, 5'h1f, 5'd31, F3_LWU, 5'd0, OPC_LOAD));
    push_word(pack_instr(7'h40, 5'h00, 5'd0, F3_LD, 5'd31, OPC_LOAD));
    push_word(pack_instr(7'h55, 5'h0a, 5'd7, 3'd0, 5'd9, OPC_LOAD));
    // register ops, every funct3 with the base funct7
    for (k = 0; k < 8; k++)
      push_word(pack_instr(F7_BASE, 5'(31 - k), 5'(k), k[2:0], 5'(k * 3), OPC_OP));
    // alternate funct7 forms, bad selectors, and a funct7 that sll ignores
    push_word(pack_instr(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP));
    push_word(pack_instr(F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OP));
    push_word(pack_instr(7'h01, 5'd4, 5'd5, F3_ADD, 5'd6, OPC_OP));
    push_word(pack_instr(7'h7f, 5'd7, 5'd8, F3_SR, 5'd9, OPC_OP));
    push_word(pack_instr(7'h7f, 5'd10, 5'd11, F3_SLL, 5'd12, OPC_OP));
    // stores: sb, sh, sw and an unlisted width, offsets at both ends
    push_word(pack_instr(7'h40, 5'd31, 5'd0, F3_SB, 5'h00, OPC_STORE));
    push_word(pack_instr(7'h3f, 5'd0, 5'd31, F3_SH, 5'h1f, OPC_STORE));
    push_word(pack_instr(7'h7f, 5'd15, 5'd16, F3_SW, 5'h1f, OPC_STORE));
    push_word(pack_instr(7'h00, 5'd1, 5'd1, 3'd3, 5'h00, OPC_STORE));
    // lui with all upper bits set, jal with an offset of -2 and the most positive offset
    push_word(pack_instr(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd5, OPC_LUI));
    push_word(pack_instr(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd31, OPC_JAL));
    push_word(pack_instr(7'h3f, 5'h1f, 5'h1f, 3'h7, 5'd0, OPC_JAL));
    hold_off();

    // random part, with one full drain halfway through
    for (k = 0; k < RANDOM_WORDS; k++) begin
      push_word(random_instr());
      if (k == RANDOM_WORDS / 2) hold_off();
      else pace_sender();
    end
    hold_off();
    // keep the clock running in case anything stray comes out of the pipeline
    repeat (8) @(posedge clk);

    $display("%0d instruction words sent, directed cases then a random mix of all six groups",
             words_sent);
    $display("%0d result beats checked field by field, receiver stalled on varying patterns",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("timed out with %0d result beats outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: riscv_instruction_field_decoder_top.f
+incdir+design
design/rvfd_pkg.sv
design/rvfd_pipe_reg.sv
design/rvfd_decode.sv
design/riscv_instruction_field_decoder_top.sv
bench/rvfd_decode_checker.sv
bench/tb.sv
